// ===== sv/universal_machine_execute_macros.svh =====
// ----------------------------------------------------------------------------
// Universal machine execute assertion macros
// Shared concurrent assertion shorthands clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef UNIVERSAL_MACHINE_EXECUTE_MACROS_SVH
`define UNIVERSAL_MACHINE_EXECUTE_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define UME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that also holds during reset.
`define UME_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/ume_pkg.sv =====
// ----------------------------------------------------------------------------
// Universal machine execute package
// Opcodes, result kinds, sequencer states and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package ume_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned RegIdxW    = 3;
  localparam int unsigned NumRegs    = 8;
  localparam int unsigned OpcodeLsb  = 28;
  localparam int unsigned ImmRegLsb  = 25;
  localparam int unsigned ImmWidth   = 25;
  localparam int unsigned IterSteps  = 32;
  localparam int unsigned CntWidth   = 5;

  typedef enum logic [3:0] {
    OP_CMOV      = 4'd0,
    OP_READ      = 4'd1,
    OP_WRITE     = 4'd2,
    OP_ADD       = 4'd3,
    OP_MUL       = 4'd4,
    OP_DIV       = 4'd5,
    OP_NAND      = 4'd6,
    OP_HALT      = 4'd7,
    OP_NEW_ARRAY = 4'd8,
    OP_FREE      = 4'd9,
    OP_OUT       = 4'd10,
    OP_IN        = 4'd11,
    OP_LOAD      = 4'd12,
    OP_IMM       = 4'd13
  } opcode_e;

  typedef enum logic [3:0] {
    KIND_DONE    = 4'd0,
    KIND_CHAR    = 4'd1,
    KIND_HALT    = 4'd2,
    KIND_ILLEGAL = 4'd3,
    KIND_DIVZERO = 4'd4,
    KIND_READ    = 4'd5,
    KIND_WRITE   = 4'd6,
    KIND_ALLOC   = 4'd7,
    KIND_FREE    = 4'd8,
    KIND_LOAD    = 4'd9
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDC,
    S_RDB,
    S_RDA,
    S_DEC,
    S_ITER,
    S_WR,
    S_OUT
  } state_e;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            out_char;
    logic [WordWidth-1:0]  word_a;
    logic [WordWidth-1:0]  word_b;
    logic [WordWidth-1:0]  word_c;
    logic [RegIdxW-1:0]    dest_reg;
    logic [3:0]            bad_opcode;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/universal_machine_execute.sv =====
// ----------------------------------------------------------------------------
// Universal machine execute
// Executes one instruction word against an eight-entry register file and
// reports one result transaction per input transaction.
// ----------------------------------------------------------------------------
//  Channel  | Direction | tuser        | tdata
//  s_axis   | in        | op           | instr, in_word, wb_reg, wb_value
//  m_axis   | out       | kind         | out_char, word_a, word_b, word_c,
//           |           |              | dest_reg, bad_opcode
//
//  Operands are read one at a time from the single read port of the register
//  file, so a new item is taken only after the last one has left S_OUT.
//  Multiply and divide run 32 shift-add or shift-subtract steps on the one
//  shared 34-bit adder before the write-back state S_WR.
//  Reset clears the valid bit of every register, so all registers read zero.
//  A result waits in the output register while the next item is taken; a
//  stalled output only holds the sequencer when the following result is done.
// ----------------------------------------------------------------------------
`default_nettype none

`include "universal_machine_execute_macros.svh"

module universal_machine_execute (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: instr[31:0], in_word[63:32], wb_reg[66:64], wb_value[98:67], zero fill
  input  wire logic [103:0] s_axis_tdata,
  // tuser: op[0]
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: out_char[7:0], word_a[39:8], word_b[71:40], word_c[103:72],
  //        dest_reg[106:104], bad_opcode[110:107], zero fill
  output logic [111:0]      m_axis_tdata,
  // tuser: kind[3:0]
  output logic [3:0]        m_axis_tuser
);

  localparam int unsigned W = ume_pkg::WordWidth;

  ume_pkg::state_e state_q, state_d;

  // Latched input transaction.
  logic                            op_q;
  logic [W-1:0]                    instr_q;
  logic [W-1:0]                    in_word_q;
  logic [ume_pkg::RegIdxW-1:0]     wb_reg_q;
  logic [W-1:0]                    wb_value_q;

  // Operand and iteration registers.
  logic [W-1:0]                    val_b_q, val_b_d;
  logic [W-1:0]                    val_c_q, val_c_d;
  logic [W-1:0]                    acc_q, acc_d;
  logic [ume_pkg::CntWidth-1:0]    cnt_q, cnt_d;

  ume_pkg::result_t                res_q, res_d;
  ume_pkg::result_t                m_res_q;
  logic                            m_valid_q, m_valid_d;
  logic                            m_load;

  // Register file with one write and one registered read port.
  logic [W-1:0]                    mem [ume_pkg::NumRegs];
  logic [ume_pkg::NumRegs-1:0]     valid_q;
  logic [W-1:0]                    rd_data_q;
  logic [ume_pkg::RegIdxW-1:0]     rd_addr;
  logic                            wr_en;
  logic [ume_pkg::RegIdxW-1:0]     wr_addr;
  logic [W-1:0]                    wr_data;

  // Shared adder.
  logic [W:0]                      add_x, add_y;
  logic                            add_sub;
  logic [W+1:0]                    add_res;
  logic                            borrow;

  logic                            s_accept;
  ume_pkg::opcode_e                opc;
  logic [ume_pkg::RegIdxW-1:0]     fa, fb, fc, imm_reg;
  logic                            is_div;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign opc      = ume_pkg::opcode_e'(instr_q[W-1:ume_pkg::OpcodeLsb]);
  assign fa       = instr_q[8:6];
  assign fb       = instr_q[5:3];
  assign fc       = instr_q[2:0];
  assign imm_reg  = instr_q[ume_pkg::ImmRegLsb +: ume_pkg::RegIdxW];
  assign is_div   = (opc == ume_pkg::OP_DIV);

  assign add_res = {1'b0, add_x} + ({1'b0, add_y} ^ {(W + 2){add_sub}})
                 + {{(W + 1){1'b0}}, add_sub};
  assign borrow  = add_res[W+1];

  always_comb begin
    add_x   = {1'b0, val_b_q};
    add_y   = {1'b0, val_c_q};
    add_sub = 1'b0;
    if (state_q == ume_pkg::S_ITER) begin
      if (is_div) begin
        // Trial subtract of the divisor from the shifted partial remainder.
        add_x   = {acc_q, val_b_q[W-1]};
        add_y   = {1'b0, val_c_q};
        add_sub = 1'b1;
      end else begin
        add_x = {1'b0, acc_q};
        add_y = {1'b0, val_b_q & {W{val_c_q[0]}}};
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    val_b_d   = val_b_q;
    val_c_d   = val_c_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_load    = 1'b0;
    rd_addr   = fc;
    wr_en     = 1'b0;
    wr_addr   = fa;
    wr_data   = val_b_q;
    s_axis_tready = 1'b0;

    case (state_q)
      ume_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ume_pkg::S_RDC;
        end
      end
      ume_pkg::S_RDC: begin
        rd_addr = fc;
        state_d = ume_pkg::S_RDB;
      end
      ume_pkg::S_RDB: begin
        val_c_d = rd_data_q;
        rd_addr = fb;
        state_d = ume_pkg::S_RDA;
      end
      ume_pkg::S_RDA: begin
        val_b_d = rd_data_q;
        rd_addr = fa;
        state_d = ume_pkg::S_DEC;
      end
      ume_pkg::S_DEC: begin
        res_d      = '0;
        res_d.kind = ume_pkg::KIND_DONE;
        state_d    = ume_pkg::S_OUT;
        acc_d      = '0;
        cnt_d      = '0;
        if (op_q) begin
          wr_en   = 1'b1;
          wr_addr = wb_reg_q;
          wr_data = wb_value_q;
        end else begin
          case (opc)
            ume_pkg::OP_CMOV: begin
              wr_en = (val_c_q != '0);
            end
            ume_pkg::OP_READ: begin
              res_d.kind     = ume_pkg::KIND_READ;
              res_d.word_a   = val_b_q;
              res_d.word_b   = val_c_q;
              res_d.dest_reg = fa;
            end
            ume_pkg::OP_WRITE: begin
              res_d.kind   = ume_pkg::KIND_WRITE;
              res_d.word_a = rd_data_q;
              res_d.word_b = val_b_q;
              res_d.word_c = val_c_q;
            end
            ume_pkg::OP_ADD: begin
              wr_en   = 1'b1;
              wr_data = add_res[W-1:0];
            end
            ume_pkg::OP_MUL: begin
              state_d = ume_pkg::S_ITER;
            end
            ume_pkg::OP_DIV: begin
              if (val_c_q == '0) begin
                res_d.kind = ume_pkg::KIND_DIVZERO;
              end else begin
                state_d = ume_pkg::S_ITER;
              end
            end
            ume_pkg::OP_NAND: begin
              wr_en   = 1'b1;
              wr_data = ~(val_b_q & val_c_q);
            end
            ume_pkg::OP_HALT: begin
              res_d.kind = ume_pkg::KIND_HALT;
            end
            ume_pkg::OP_NEW_ARRAY: begin
              res_d.kind     = ume_pkg::KIND_ALLOC;
              res_d.word_a   = val_c_q;
              res_d.dest_reg = fb;
            end
            ume_pkg::OP_FREE: begin
              res_d.kind   = ume_pkg::KIND_FREE;
              res_d.word_a = val_c_q;
            end
            ume_pkg::OP_OUT: begin
              res_d.kind     = ume_pkg::KIND_CHAR;
              res_d.out_char = val_c_q[7:0];
            end
            ume_pkg::OP_IN: begin
              wr_en   = 1'b1;
              wr_addr = fc;
              wr_data = in_word_q;
            end
            ume_pkg::OP_LOAD: begin
              res_d.kind   = ume_pkg::KIND_LOAD;
              res_d.word_a = val_b_q;
              res_d.word_b = val_c_q;
            end
            ume_pkg::OP_IMM: begin
              wr_en   = 1'b1;
              wr_addr = imm_reg;
              wr_data = {{(W - ume_pkg::ImmWidth){1'b0}},
                         instr_q[ume_pkg::ImmWidth-1:0]};
            end
            default: begin
              res_d.kind       = ume_pkg::KIND_ILLEGAL;
              res_d.bad_opcode = instr_q[W-1:ume_pkg::OpcodeLsb];
            end
          endcase
        end
      end
      ume_pkg::S_ITER: begin
        if (is_div) begin
          // Restoring division: val_b_q shifts the dividend out and the
          // quotient in, acc_q holds the partial remainder.
          acc_d   = borrow ? {acc_q[W-2:0], val_b_q[W-1]} : add_res[W-1:0];
          val_b_d = {val_b_q[W-2:0], !borrow};
        end else begin
          acc_d   = add_res[W-1:0];
          val_b_d = {val_b_q[W-2:0], 1'b0};
          val_c_d = {1'b0, val_c_q[W-1:1]};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ume_pkg::CntWidth'(ume_pkg::IterSteps - 1)) begin
          state_d = ume_pkg::S_WR;
        end
      end
      ume_pkg::S_WR: begin
        wr_en   = 1'b1;
        wr_addr = fa;
        wr_data = is_div ? val_b_q : acc_q;
        state_d = ume_pkg::S_OUT;
      end
      ume_pkg::S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_load    = 1'b1;
          m_valid_d = 1'b1;
          state_d   = ume_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ume_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ume_pkg::S_IDLE;
      m_valid_q <= 1'b0;
      valid_q   <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      cnt_q     <= cnt_d;
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q       <= s_axis_tuser[0];
      instr_q    <= s_axis_tdata[31:0];
      in_word_q  <= s_axis_tdata[63:32];
      wb_reg_q   <= s_axis_tdata[66:64];
      wb_value_q <= s_axis_tdata[98:67];
    end
    val_b_q <= val_b_d;
    val_c_q <= val_c_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
    if (m_load) begin
      m_res_q <= res_q;
    end
  end

  // Register file storage; an entry never written since reset reads zero.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.kind;
  assign m_axis_tdata  = {1'b0, m_res_q.bad_opcode, m_res_q.dest_reg, m_res_q.word_c,
                          m_res_q.word_b, m_res_q.word_a, m_res_q.out_char};

  `UME_ASSERT(a_accept_starts_read, s_accept |=> state_q == ume_pkg::S_RDC,
              "accepted transaction did not start the operand reads")
  `UME_ASSERT(a_iter_ends,
              (state_q == ume_pkg::S_ITER &&
               cnt_q == ume_pkg::CntWidth'(ume_pkg::IterSteps - 1))
              |=> state_q == ume_pkg::S_WR,
              "iteration did not end after the last step")
  `UME_ASSERT(a_write_states, wr_en |-> (state_q == ume_pkg::S_DEC || state_q == ume_pkg::S_WR),
              "register file written outside decode or write-back")
  `UME_ASSERT(a_divzero_no_write,
              (state_q == ume_pkg::S_DEC && !op_q && is_div && val_c_q == '0) |-> !wr_en,
              "divide by zero changed a register")
  `UME_ASSERT_ALWAYS(a_ready_idle, s_axis_tready |-> !m_load,
              "input taken while a result was being loaded")

endmodule

`default_nettype wire

// ===== tb/sv/tb_universal_machine_execute.sv =====
// ----------------------------------------------------------------------------
// Universal machine execute testbench
// Drives instruction and write-back transactions into the executor, keeps a
// shadow register file to predict every result transaction, and compares
// each returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_universal_machine_execute;
  import ume_pkg::*;

  // Opcodes outside the defined set.
  localparam logic [3:0] OP_UNDEF_LO = 4'd14;
  localparam logic [3:0] OP_UNDEF_HI = 4'd15;
  localparam int unsigned RandomItems = 1475;
  localparam int unsigned CalmFrom    = 1300;
  localparam int unsigned HoldOffAt   = 400;
  localparam int unsigned HoldOffLen  = 300;

  class machine_scoreboard;
    logic [WordWidth-1:0] shadow_regs [NumRegs];
    result_t pending_results [$];
    int errors;
    int checked;
    int kind_count [16];

    function new();
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      foreach (kind_count[i]) kind_count[i] = 0;
      errors  = 0;
      checked = 0;
    endfunction

    // Applies one accepted input transaction to the shadow registers and
    // queues the result it must produce.
    function void note_item(bit op, logic [31:0] instr, logic [31:0] in_word,
                            logic [2:0] wb_reg, logic [31:0] wb_value);
      result_t r;
      logic [2:0] ra, rb, rc;
      r = '0;
      r.kind = KIND_DONE;
      ra = instr[8:6];
      rb = instr[5:3];
      rc = instr[2:0];
      if (op) begin
        shadow_regs[wb_reg] = wb_value;
      end else begin
        case (opcode_e'(instr[31:28]))
          OP_CMOV: begin
            if (shadow_regs[rc] != '0) shadow_regs[ra] = shadow_regs[rb];
          end
          OP_READ: begin
            r.kind = KIND_READ;
            r.word_a = shadow_regs[rb];
            r.word_b = shadow_regs[rc];
            r.dest_reg = ra;
          end
          OP_WRITE: begin
            r.kind = KIND_WRITE;
            r.word_a = shadow_regs[ra];
            r.word_b = shadow_regs[rb];
            r.word_c = shadow_regs[rc];
          end
          OP_ADD: shadow_regs[ra] = shadow_regs[rb] + shadow_regs[rc];
          OP_MUL: shadow_regs[ra] = shadow_regs[rb] * shadow_regs[rc];
          OP_DIV: begin
            if (shadow_regs[rc] == '0) r.kind = KIND_DIVZERO;
            else shadow_regs[ra] = shadow_regs[rb] / shadow_regs[rc];
          end
          OP_NAND: shadow_regs[ra] = ~(shadow_regs[rb] & shadow_regs[rc]);
          OP_HALT: r.kind = KIND_HALT;
          OP_NEW_ARRAY: begin
            r.kind = KIND_ALLOC;
            r.word_a = shadow_regs[rc];
            r.dest_reg = rb;
          end
          OP_FREE: begin
            r.kind = KIND_FREE;
            r.word_a = shadow_regs[rc];
          end
          OP_OUT: begin
            r.kind = KIND_CHAR;
            r.out_char = shadow_regs[rc][7:0];
          end
          OP_IN: shadow_regs[rc] = in_word;
          OP_LOAD: begin
            r.kind = KIND_LOAD;
            r.word_a = shadow_regs[rb];
            r.word_b = shadow_regs[rc];
          end
          OP_IMM: shadow_regs[instr[27:25]] = {7'd0, instr[24:0]};
          default: begin
            r.kind = KIND_ILLEGAL;
            r.bad_opcode = instr[31:28];
          end
        endcase
      end
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [3:0] kind, logic [111:0] data);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction with no instruction pending: kind %0d", kind);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      kind_count[want.kind]++;
      compare_field("kind", want.kind, kind);
      compare_field("out_char", want.out_char, data[7:0]);
      compare_field("word_a", want.word_a, data[39:8]);
      compare_field("word_b", want.word_b, data[71:40]);
      compare_field("word_c", want.word_c, data[103:72]);
      compare_field("dest_reg", want.dest_reg, data[106:104]);
      compare_field("bad_opcode", want.bad_opcode, data[110:107]);
    endfunction
  endclass

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata  = '0;
  logic [0:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;

  machine_scoreboard sb = new();
  int  items_sent  = 0;
  int  tx_gap_pct  = 0;
  int  rx_idle_pct = 0;
  bit  calm        = 1'b0;
  bit  held_off    = 1'b0;

  universal_machine_execute dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Half corner values, so that wrap-around arithmetic gets exercised.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Unused instruction bits are filled at random.
  function automatic logic [31:0] make_word(logic [3:0] opc, logic [2:0] a,
                                            logic [2:0] b, logic [2:0] c);
    logic [31:0] w;
    w = $urandom;
    w[31:28] = opc;
    w[8:6] = a;
    w[5:3] = b;
    w[2:0] = c;
    return w;
  endfunction

  task automatic send_item(bit op, logic [31:0] instr, logic [31:0] in_word,
                           logic [2:0] wb_reg, logic [31:0] wb_value);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, wb_value, wb_reg, in_word, instr};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, instr, in_word, wb_reg, wb_value);
    items_sent++;
    if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic run_word(logic [3:0] opc, logic [2:0] a, logic [2:0] b,
                          logic [2:0] c, logic [31:0] in_word);
    send_item(1'b0, make_word(opc, a, b, c), in_word, 3'($urandom_range(0, 7)), $urandom);
  endtask

  task automatic write_back(logic [2:0] r, logic [31:0] value);
    send_item(1'b1, $urandom, $urandom, r, value);
  endtask

  task automatic load_imm(logic [2:0] r, logic [24:0] imm);
    send_item(1'b0, {OP_IMM, r, imm}, $urandom, 3'($urandom_range(0, 7)), $urandom);
  endtask

  // Result side: random stall bursts, plus one long hold-off that backs the
  // block up until its input stalls.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
      if (!held_off && items_sent >= HoldOffAt) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
        stall_left = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int p;
    logic [3:0] opc;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: operand extremes, every opcode, and the special cases.
    write_back(3'd2, 32'hFFFF_FFFF);
    write_back(3'd3, 32'h8000_0001);
    load_imm(3'd1, 25'h1FF_FFFF);
    load_imm(3'd7, 25'h000_0000);
    run_word(OP_ADD, 3'd4, 3'd2, 3'd3, '0);       // carry out of bit 31
    run_word(OP_MUL, 3'd5, 3'd2, 3'd2, '0);       // product wraps to one
    run_word(OP_DIV, 3'd6, 3'd2, 3'd1, '0);
    run_word(OP_DIV, 3'd0, 3'd2, 3'd7, '0);       // divisor is zero
    run_word(OP_NAND, 3'd0, 3'd2, 3'd3, '0);
    run_word(OP_CMOV, 3'd4, 3'd1, 3'd7, '0);      // condition zero, no move
    run_word(OP_CMOV, 3'd4, 3'd1, 3'd2, '0);
    run_word(OP_IN, 3'd0, 3'd0, 3'd6, 32'hFFFF_FFFF);
    run_word(OP_IN, 3'd0, 3'd0, 3'd5, 32'h0000_0000);
    run_word(OP_OUT, 3'd0, 3'd0, 3'd3, '0);       // high bits must be dropped
    run_word(OP_OUT, 3'd0, 3'd0, 3'd2, '0);
    run_word(OP_READ, 3'd0, 3'd2, 3'd3, '0);
    run_word(OP_WRITE, 3'd2, 3'd3, 3'd4, '0);
    run_word(OP_NEW_ARRAY, 3'd0, 3'd7, 3'd2, '0);
    run_word(OP_FREE, 3'd0, 3'd0, 3'd3, '0);
    run_word(OP_LOAD, 3'd0, 3'd1, 3'd2, '0);
    run_word(OP_HALT, 3'd0, 3'd0, 3'd0, '0);
    run_word(OP_ADD, 3'd0, 3'd1, 3'd2, '0);       // execution goes on after halt
    run_word(OP_UNDEF_LO, 3'd7, 3'd7, 3'd7, '0);
    run_word(OP_UNDEF_HI, 3'd0, 3'd0, 3'd0, '0);
    write_back(3'd0, 32'h0000_0000);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 15;
          default: tx_gap_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0: rx_idle_pct = 0;
          1: rx_idle_pct = 10;
          default: rx_idle_pct = 40;
        endcase
      end
      if (n == CalmFrom) calm = 1'b1;
      p = $urandom_range(0, 99);
      if (p < 18) begin
        write_back(3'($urandom_range(0, 7)), pick_word());
      end else if (p < 28) begin
        load_imm(3'($urandom_range(0, 7)), 25'($urandom));
      end else if (p < 32) begin
        opc = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
        run_word(opc, 3'($urandom), 3'($urandom), 3'($urandom), pick_word());
      end else begin
        opc = 4'($urandom_range(0, 12));
        run_word(opc, 3'($urandom), 3'($urandom), 3'($urandom), pick_word());
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Executed %0d transactions; %0d results compared, %0d mismatches.",
             items_sent, sb.checked, sb.errors);
    $display("Kinds: done %0d, char %0d, halt %0d, illegal %0d, div-zero %0d, %s %0d",
             sb.kind_count[KIND_DONE], sb.kind_count[KIND_CHAR],
             sb.kind_count[KIND_HALT], sb.kind_count[KIND_ILLEGAL],
             sb.kind_count[KIND_DIVZERO], "memory requests",
             sb.kind_count[KIND_READ] + sb.kind_count[KIND_WRITE] +
             sb.kind_count[KIND_ALLOC] + sb.kind_count[KIND_FREE] +
             sb.kind_count[KIND_LOAD]);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/ume_pkg.sv
sv/universal_machine_execute.sv
tb/sv/tb_universal_machine_execute.sv
